// ===== hdl/vcg_pkg.sv =====
// Shared types, codes and widths of the velocity command governor.
`timescale 1ns / 1ps
`default_nettype none

package vcg_pkg;

  // Field widths of the velocity format, the age counter, the limit registers and the configuration port.
  localparam int VEL_WIDTH      = 16;
  localparam int AGE_WIDTH      = 16;
  localparam int LIM_WIDTH      = 15;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  // Derived widths of the shared square root / divide unit.
  localparam int MAG_WIDTH  = VEL_WIDTH + 1;
  localparam int SUM_WIDTH  = 2 * VEL_WIDTH;
  localparam int ROOT_WIDTH = VEL_WIDTH;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;
  localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);

  typedef enum logic [1:0] {
    CMD_VELOCITY = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_EVALUATE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_WAIT     = 3'd0,
    STS_MOVE     = 3'd1,
    STS_STALE    = 3'd2,
    STS_INVALID  = 3'd3,
    STS_DEADBAND = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_TIMEOUT     = 3'd0,
    CFG_LIN_THRESH  = 3'd1,
    CFG_ANG_THRESH  = 3'd2,
    CFG_MAX_LINEAR  = 3'd3,
    CFG_MAX_ANGULAR = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_L,
    ST_CHECK,
    ST_SQRT,
    ST_PX,
    ST_DX_GO,
    ST_DX_RUN,
    ST_PY,
    ST_DY_GO,
    ST_DY_RUN,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the shift-subtract unit.
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } unit_ctl_t;

  // Status from the shift-subtract unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_nz;
  } unit_sts_t;

endpackage

`default_nettype wire

// ===== hdl/velocity_command_governor.sv =====
// Top level of the velocity command governor: sequencer, held command and output register.
//
// The input channel (in_*) carries three kinds of transaction, selected by in_tuser:
// a new velocity command, a time tick, or an evaluate request. Velocity and tick
// transactions update the held command and the saturating age counter in the cycle
// they are accepted; the block is ready again in the next cycle and produces no
// result. An evaluate request produces exactly one result transaction on the
// output channel (out_*): wait, move, stale stop, invalid stop or dead-band stop.
// A stop or wait result goes from the decide state straight to the emit state; an
// unscaled move first forms the squares. For a move whose planar vector is over the
// linear limit, the shared shift-subtract unit runs 16 steps for the ceiling square
// root of vx^2+vy^2 and 16 steps for each of the two scaling divisions, and one
// 17x17 multiplier forms the squares and the scaled numerators one per cycle.
// The block takes one evaluate at a time; in_tready is low while it works.
// The result sits in an output register, so velocity and tick transactions are
// still accepted while out_tvalid waits on a stalled receiver; a second evaluate
// finishes its work and then holds until the register is free.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user must write
// it only while the block is idle; the block does not enforce this. Synchronous active-low
// reset restores register defaults, clears held command and age counter, empties output.
`timescale 1ns / 1ps
`default_nettype none

module velocity_command_governor (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel.
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [55:0]                            in_tdata,  // vx, vy, yaw, invalid
  input  wire logic [1:0]                             in_tuser,  // command
  // Result channel.
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [63:0]                                 out_tdata, // vx, vy, yaw, age
  output logic [2:0]                                  out_tuser, // status
  // Configuration write port.
  input  wire logic                                   cfg_we,
  input  wire logic [vcg_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
  input  wire logic [vcg_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);

  localparam int VW = vcg_pkg::VEL_WIDTH;
  localparam int AW = vcg_pkg::AGE_WIDTH;
  localparam int LW = vcg_pkg::LIM_WIDTH;
  localparam int GW = vcg_pkg::MAG_WIDTH;
  localparam int SW = vcg_pkg::SUM_WIDTH;
  localparam int RW = vcg_pkg::ROOT_WIDTH;

  vcg_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [AW-1:0] timeout_r;
  logic [LW-1:0] lin_thr_r, ang_thr_r, max_lin_r, max_ang_r;

  // Held command and age.
  logic          have_r;
  logic [VW-1:0] held_vx_r, held_vy_r, held_yaw_r;
  logic          held_inv_r;
  logic [AW-1:0] age_r;

  // Datapath and result registers.
  logic [SW-1:0]          prod_r, sum_r;
  logic [RW-1:0]          r_r;
  vcg_pkg::status_t       res_status_r, out_status_r;
  logic [VW-1:0]          res_vx_r, res_vy_r, res_yaw_r;
  logic [VW-1:0]          out_vx_r, out_vy_r, out_yaw_r;
  logic [AW-1:0]          res_age_r, out_age_r;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic                   out_free;
  vcg_pkg::unit_ctl_t     u_ctl;
  vcg_pkg::unit_sts_t     u_sts;
  logic [SW-1:0]          u_operand;
  logic [RW-1:0]          u_result;

  logic [GW-1:0]          vx_ext, vy_ext, yaw_ext;
  logic [GW-1:0]          mag_vx, mag_vy, mag_yaw;
  logic [GW-1:0]          max_ang_ext, neg_max_ang;
  logic [VW-1:0]          yaw_clamped;
  vcg_pkg::status_t       dec_status;
  logic [GW-1:0]          mul_a, mul_b;
  logic [2*GW-1:0]        mul_full;
  logic                   scale_needed;

  assign in_tready = (state_r == vcg_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // Magnitudes are one bit wider so that the most negative value stays exact.
  always_comb begin
    vx_ext  = {held_vx_r[VW-1], held_vx_r};
    vy_ext  = {held_vy_r[VW-1], held_vy_r};
    yaw_ext = {held_yaw_r[VW-1], held_yaw_r};
    mag_vx  = vx_ext[GW-1]  ? (~vx_ext + 1'b1)  : vx_ext;
    mag_vy  = vy_ext[GW-1]  ? (~vy_ext + 1'b1)  : vy_ext;
    mag_yaw = yaw_ext[GW-1] ? (~yaw_ext + 1'b1) : yaw_ext;

    max_ang_ext = {{(GW-LW){1'b0}}, max_ang_r};
    neg_max_ang = ~max_ang_ext + 1'b1;
    if ($signed(yaw_ext) > $signed(max_ang_ext)) begin
      yaw_clamped = max_ang_ext[VW-1:0];
    end else if ($signed(yaw_ext) < $signed(neg_max_ang)) begin
      yaw_clamped = neg_max_ang[VW-1:0];
    end else begin
      yaw_clamped = held_yaw_r;
    end

    // Checks in priority order: no command, stale, invalid, dead-band, move.
    priority if (!have_r) begin
      dec_status = vcg_pkg::STS_WAIT;
    end else if (age_r > timeout_r) begin
      dec_status = vcg_pkg::STS_STALE;
    end else if (held_inv_r) begin
      dec_status = vcg_pkg::STS_INVALID;
    end else if ((mag_vx < {{(GW-LW){1'b0}}, lin_thr_r}) &&
                 (mag_vy < {{(GW-LW){1'b0}}, lin_thr_r}) &&
                 (mag_yaw < {{(GW-LW){1'b0}}, ang_thr_r})) begin
      dec_status = vcg_pkg::STS_DEADBAND;
    end else begin
      dec_status = vcg_pkg::STS_MOVE;
    end
  end

  // The one multiplier: squares first, then the scaled numerators.
  always_comb begin
    unique case (state_r)
      vcg_pkg::ST_MUL_Y: begin
        mul_a = mag_vy;
        mul_b = mag_vy;
      end
      vcg_pkg::ST_MUL_L: begin
        mul_a = {{(GW-LW){1'b0}}, max_lin_r};
        mul_b = {{(GW-LW){1'b0}}, max_lin_r};
      end
      vcg_pkg::ST_PX: begin
        mul_a = mag_vx;
        mul_b = {{(GW-LW){1'b0}}, max_lin_r};
      end
      vcg_pkg::ST_PY: begin
        mul_a = mag_vy;
        mul_b = {{(GW-LW){1'b0}}, max_lin_r};
      end
      default: begin
        mul_a = mag_vx;
        mul_b = mag_vx;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // In the check state prod_r holds max_linear squared.
  assign scale_needed = (sum_r > prod_r);
  assign u_operand    = (state_r == vcg_pkg::ST_CHECK) ? sum_r : prod_r;

  // Sequencer: next state and unit control.
  always_comb begin
    state_nxt       = state_r;
    u_ctl.start     = 1'b0;
    u_ctl.sqrt_mode = 1'b0;
    unique case (state_r)
      vcg_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == vcg_pkg::CMD_EVALUATE)) begin
          state_nxt = vcg_pkg::ST_DECIDE;
        end
      end
      vcg_pkg::ST_DECIDE: begin
        state_nxt = (dec_status == vcg_pkg::STS_MOVE) ? vcg_pkg::ST_MUL_X : vcg_pkg::ST_EMIT;
      end
      vcg_pkg::ST_MUL_X: state_nxt = vcg_pkg::ST_MUL_Y;
      vcg_pkg::ST_MUL_Y: state_nxt = vcg_pkg::ST_MUL_L;
      vcg_pkg::ST_MUL_L: state_nxt = vcg_pkg::ST_CHECK;
      vcg_pkg::ST_CHECK: begin
        if (scale_needed) begin
          u_ctl.start     = 1'b1;
          u_ctl.sqrt_mode = 1'b1;
          state_nxt       = vcg_pkg::ST_SQRT;
        end else begin
          state_nxt = vcg_pkg::ST_EMIT;
        end
      end
      vcg_pkg::ST_SQRT: begin
        if (u_sts.done) begin
          state_nxt = vcg_pkg::ST_PX;
        end
      end
      vcg_pkg::ST_PX: state_nxt = vcg_pkg::ST_DX_GO;
      vcg_pkg::ST_DX_GO: begin
        u_ctl.start = 1'b1;
        state_nxt   = vcg_pkg::ST_DX_RUN;
      end
      vcg_pkg::ST_DX_RUN: begin
        if (u_sts.done) begin
          state_nxt = vcg_pkg::ST_PY;
        end
      end
      vcg_pkg::ST_PY: state_nxt = vcg_pkg::ST_DY_GO;
      vcg_pkg::ST_DY_GO: begin
        u_ctl.start = 1'b1;
        state_nxt   = vcg_pkg::ST_DY_RUN;
      end
      vcg_pkg::ST_DY_RUN: begin
        if (u_sts.done) begin
          state_nxt = vcg_pkg::ST_EMIT;
        end
      end
      vcg_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = vcg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vcg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  vcg_shift_sub u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (u_ctl),
    .operand (u_operand),
    .divisor (r_r),
    .sts     (u_sts),
    .result  (u_result)
  );

  // Configuration, held command and age counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= AW'(500);
      lin_thr_r  <= LW'(205);
      ang_thr_r  <= LW'(205);
      max_lin_r  <= LW'(2048);
      max_ang_r  <= LW'(2048);
      have_r     <= 1'b0;
      held_vx_r  <= '0;
      held_vy_r  <= '0;
      held_yaw_r <= '0;
      held_inv_r <= 1'b0;
      age_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          vcg_pkg::CFG_TIMEOUT:     timeout_r <= cfg_wdata[AW-1:0];
          vcg_pkg::CFG_LIN_THRESH:  lin_thr_r <= cfg_wdata[LW-1:0];
          vcg_pkg::CFG_ANG_THRESH:  ang_thr_r <= cfg_wdata[LW-1:0];
          vcg_pkg::CFG_MAX_LINEAR:  max_lin_r <= cfg_wdata[LW-1:0];
          vcg_pkg::CFG_MAX_ANGULAR: max_ang_r <= cfg_wdata[LW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_tuser)
          vcg_pkg::CMD_VELOCITY: begin
            held_vx_r  <= in_tdata[VW-1:0];
            held_vy_r  <= in_tdata[2*VW-1:VW];
            held_yaw_r <= in_tdata[3*VW-1:2*VW];
            held_inv_r <= in_tdata[3*VW];
            have_r     <= 1'b1;
            age_r      <= '0;
          end
          vcg_pkg::CMD_TICK: begin
            if (age_r != {AW{1'b1}}) begin
              age_r <= age_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath and result staging.
  always_ff @(posedge clk) begin
    unique case (state_r)
      vcg_pkg::ST_DECIDE: begin
        res_status_r <= dec_status;
        res_age_r    <= have_r ? age_r : '0;
        if (dec_status == vcg_pkg::STS_MOVE) begin
          res_vx_r  <= held_vx_r;
          res_vy_r  <= held_vy_r;
          res_yaw_r <= yaw_clamped;
        end else begin
          res_vx_r  <= '0;
          res_vy_r  <= '0;
          res_yaw_r <= '0;
        end
      end
      vcg_pkg::ST_MUL_X: prod_r <= mul_full[SW-1:0];
      vcg_pkg::ST_MUL_Y: begin
        sum_r  <= prod_r;
        prod_r <= mul_full[SW-1:0];
      end
      vcg_pkg::ST_MUL_L: begin
        sum_r  <= sum_r + prod_r;
        prod_r <= mul_full[SW-1:0];
      end
      vcg_pkg::ST_SQRT: begin
        // A nonzero remainder rounds the root up.
        if (u_sts.done) begin
          r_r <= u_result + {{(RW-1){1'b0}}, u_sts.rem_nz};
        end
      end
      vcg_pkg::ST_PX, vcg_pkg::ST_PY: prod_r <= mul_full[SW-1:0];
      vcg_pkg::ST_DX_RUN: begin
        if (u_sts.done) begin
          res_vx_r <= held_vx_r[VW-1] ? (~u_result + 1'b1) : u_result;
        end
      end
      vcg_pkg::ST_DY_RUN: begin
        if (u_sts.done) begin
          res_vy_r <= held_vy_r[VW-1] ? (~u_result + 1'b1) : u_result;
        end
      end
      vcg_pkg::ST_EMIT: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_vx_r     <= res_vx_r;
          out_vy_r     <= res_vy_r;
          out_yaw_r    <= res_yaw_r;
          out_age_r    <= res_age_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if ((state_r == vcg_pkg::ST_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_age_r, out_yaw_r, out_vy_r, out_vx_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // The shared unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    u_sts.done |-> ((state_r == vcg_pkg::ST_SQRT) || (state_r == vcg_pkg::ST_DX_RUN) ||
                    (state_r == vcg_pkg::ST_DY_RUN)))
    else $error("shift-subtract unit finished outside a wait state");

  // Every non-move result carries zero velocities.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != vcg_pkg::STS_MOVE)) |-> (out_tdata[3*VW-1:0] == '0))
    else $error("stop or wait result with nonzero velocity");

  // An accepted evaluate request starts the sequencer in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == vcg_pkg::CMD_EVALUATE)) |=> (state_r == vcg_pkg::ST_DECIDE))
    else $error("evaluate transaction did not start the sequencer");

  // The age counter only goes down when a new velocity command arrives.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_tuser == vcg_pkg::CMD_VELOCITY)) |=> (age_r >= $past(age_r)))
    else $error("age counter decreased without a new command");
`endif

endmodule

`default_nettype wire

// ===== hdl/vcg_shift_sub.sv =====
// Shared shift-subtract unit: bit-serial integer square root and restoring division.
`timescale 1ns / 1ps
`default_nettype none

module vcg_shift_sub (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire vcg_pkg::unit_ctl_t                  ctl,
  input  wire logic [vcg_pkg::SUM_WIDTH-1:0]       operand,
  input  wire logic [vcg_pkg::ROOT_WIDTH-1:0]      divisor,
  output vcg_pkg::unit_sts_t                       sts,
  output logic [vcg_pkg::ROOT_WIDTH-1:0]           result
);

  localparam int SW = vcg_pkg::SUM_WIDTH;
  localparam int RW = vcg_pkg::ROOT_WIDTH;
  localparam int MW = vcg_pkg::REM_WIDTH;
  localparam int CW = vcg_pkg::CNT_WIDTH;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          sqrt_r, sqrt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] src_r, src_nxt;

  logic [MW+1:0] shifted;
  logic [MW+1:0] trial;
  logic [MW+2:0] diff;
  logic          ge;

  // Square root brings down two bits a step and tries 4*root+1; division brings
  // down one bit and tries the divisor.
  always_comb begin
    if (sqrt_r) begin
      shifted = {rem_r, src_r[SW-1 -: 2]};
      trial   = {2'b00, acc_r, 2'b01};
    end else begin
      shifted = {1'b0, rem_r, src_r[SW-1]};
      trial   = {{(MW+2-RW){1'b0}}, divisor};
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    ge   = ~diff[MW+2];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    src_nxt  = src_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = ctl.sqrt_mode;
      cnt_nxt  = CW'(RW - 1);
      acc_nxt  = '0;
      if (ctl.sqrt_mode) begin
        rem_nxt = '0;
        src_nxt = operand;
      end else begin
        // The quotient fits in RW bits, so the top half is already below the divisor.
        rem_nxt = {{(MW-(SW-RW)){1'b0}}, operand[SW-1:RW]};
        src_nxt = {operand[RW-1:0], {(SW-RW){1'b0}}};
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[MW-1:0] : shifted[MW-1:0];
      acc_nxt = {acc_r[RW-2:0], ge};
      src_nxt = sqrt_r ? {src_r[SW-3:0], 2'b00} : {src_r[SW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    src_r  <= src_nxt;
  end

  assign sts.done   = done_r;
  assign sts.rem_nz = |rem_r;
  assign result     = acc_r;

endmodule

`default_nettype wire

// ===== tb/tb_velocity_command_governor.sv =====
// Self-checking testbench for the velocity command governor.
`timescale 1ns / 1ps

module tb_velocity_command_governor;
  import vcg_pkg::*;

  // The command field is two bits wide, so the one code without a meaning can
  // still be sent. The block must drop it without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles allowed after the last result before the block counts as idle. The
  // slowest evaluate runs the square root and two divisions.
  localparam int DRAIN_CYCLES = 80;
  // Length of the long receiver stall in the back-pressure test.
  localparam int HOLD_CYCLES = 400;
  // Random transactions per configuration phase (eight phases).
  localparam int ITEMS_PER_PHASE = 140;

  // One result of an evaluate transaction, as the block should send it.
  typedef struct {
    status_t     status;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] yaw;
    logic [15:0] age;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // vx[15:0], vy[31:16], yaw[47:32], invalid[48], zero fill
  logic [1:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // vx[15:0], vy[31:16], yaw[47:32], age[63:48]
  logic [2:0]  out_tuser;  // status
  logic        cfg_we;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

  // Predictor state: the held command, its age and the register file, all
  // starting from their reset values.
  logic               seen_command   = 1'b0;
  logic signed [15:0] stored_vx      = '0;
  logic signed [15:0] stored_vy      = '0;
  logic signed [15:0] stored_yaw     = '0;
  logic               stored_invalid = 1'b0;
  logic [15:0]        cmd_age        = '0;
  logic [15:0]        timeout_reg    = 16'd500;
  logic [14:0]        lin_thresh_reg = 15'd205;
  logic [14:0]        ang_thresh_reg = 15'd205;
  logic [14:0]        lin_max_reg    = 15'd2048;
  logic [14:0]        ang_max_reg    = 15'd2048;

  // Results predicted for accepted evaluate transactions, oldest first.
  verdict_t pending_verdicts[$];

  // When set, neither side inserts idle cycles.
  bit no_gaps     = 1'b0;
  // Idle cycles the receiver still has to wait, and a request for a long hold.
  int rx_wait     = 0;
  int rx_hold_req = 0;
  int mismatches  = 0;

  velocity_command_governor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact magnitude; the most negative value becomes +32768 in 17 bits.
  function automatic logic [16:0] magnitude(logic signed [15:0] v);
    logic signed [16:0] w;
    w = v;
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

  // Ceiling of the square root. The sum of two squares stays below 2^32, so the
  // root has at most 17 bits.
  function automatic longint unsigned ceil_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    if (root * root < n) root++;
    return root;
  endfunction

  // v * lim / root with the quotient truncated toward zero.
  function automatic logic [15:0] scale_component(logic signed [15:0] v,
                                                  longint unsigned lim,
                                                  longint unsigned root);
    longint unsigned quot;
    quot = magnitude(v);
    quot = (quot * lim) / root;
    return v[15] ? 16'(-quot) : 16'(quot);
  endfunction

  // Result of an evaluate transaction for the current held command, age and
  // registers. The checks go in a fixed order: no command yet, stale, invalid,
  // dead-band, and only then a move.
  function automatic verdict_t govern();
    verdict_t        res;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned lim;
    longint unsigned sq;
    longint unsigned root;
    longint          yaw_l;
    longint          ang_l;
    res = '{STS_WAIT, 16'd0, 16'd0, 16'd0, 16'd0};
    // Before the first command even the age field stays zero.
    if (!seen_command) return res;
    res.age = cmd_age;
    ax = magnitude(stored_vx);
    ay = magnitude(stored_vy);
    if (cmd_age > timeout_reg) begin
      res.status = STS_STALE;
    end else if (stored_invalid) begin
      res.status = STS_INVALID;
    end else if (ax < lin_thresh_reg && ay < lin_thresh_reg &&
                 magnitude(stored_yaw) < ang_thresh_reg) begin
      res.status = STS_DEADBAND;
    end else begin
      res.status = STS_MOVE;
      res.vx = stored_vx;
      res.vy = stored_vy;
      lim = lin_max_reg;
      sq = ax * ax + ay * ay;
      // Scale only when the vector is strictly longer than the limit; a zero
      // vector therefore never reaches the division.
      if (sq > lim * lim) begin
        root = ceil_root(sq);
        res.vx = scale_component(stored_vx, lim, root);
        res.vy = scale_component(stored_vy, lim, root);
      end
      yaw_l = stored_yaw;
      ang_l = ang_max_reg;
      if (yaw_l > ang_l) yaw_l = ang_l;
      else if (yaw_l < -ang_l) yaw_l = -ang_l;
      res.yaw = 16'(yaw_l);
    end
    return res;
  endfunction

  // Applies one accepted input transaction to the predictor.
  function automatic void apply_item(logic [1:0] cmd, logic signed [15:0] vx,
                                     logic signed [15:0] vy, logic signed [15:0] yaw,
                                     logic inv);
    case (cmd)
      CMD_VELOCITY: begin
        stored_vx      = vx;
        stored_vy      = vy;
        stored_yaw     = yaw;
        stored_invalid = inv;
        seen_command   = 1'b1;
        cmd_age        = '0;
      end
      CMD_TICK: begin
        // The age counter saturates instead of wrapping.
        if (cmd_age != 16'hFFFF) cmd_age++;
      end
      CMD_EVALUATE: pending_verdicts.push_back(govern());
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one input transaction after a random gap and waits for acceptance.
  // in_tvalid stays high on return so back-to-back transactions follow without a gap;
  // the next call that draws a gap, or drain(), lowers it.
  task automatic send_item(logic [1:0] cmd, logic signed [15:0] vx,
                           logic signed [15:0] vy, logic signed [15:0] yaw,
                           logic inv);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {7'd0, inv, yaw, vy, vx};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    apply_item(cmd, vx, vy, yaw, inv);
    @(negedge clk);
  endtask

  // A transaction whose data fields are random; for ticks, evaluates and the
  // unused code the block must ignore them.
  task automatic send_random(logic [1:0] cmd);
    send_item(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Stops offering, waits for every predicted result, then lets the block
  // settle so that it is surely idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; the predictor keeps only the register's width.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_TIMEOUT:     timeout_reg    = value;
      CFG_LIN_THRESH:  lin_thresh_reg = value[14:0];
      CFG_ANG_THRESH:  ang_thresh_reg = value[14:0];
      CFG_MAX_LINEAR:  lin_max_reg    = value[14:0];
      CFG_MAX_ANGULAR: ang_max_reg    = value[14:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Brings the block to idle and writes all five registers.
  task automatic configure(logic [15:0] timeout, logic [15:0] lin_thr,
                           logic [15:0] ang_thr, logic [15:0] lin_max,
                           logic [15:0] ang_max);
    drain();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_LIN_THRESH, lin_thr);
    write_reg(CFG_ANG_THRESH, ang_thr);
    write_reg(CFG_MAX_LINEAR, lin_max);
    write_reg(CFG_MAX_ANGULAR, ang_max);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result checker
  // ---------------------------------------------------------------------------

  // The receiver counts its idle cycles here; the checker draws a new wait
  // after each accepted result, and a hold request overrides it.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_wait     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_wait = no_gaps ? 0 : $urandom_range(0, 9);
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing pending: status %0d data %h", $realtime,
                   out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.status || out_tdata[15:0] !== want.vx ||
            out_tdata[31:16] !== want.vy || out_tdata[47:32] !== want.yaw ||
            out_tdata[63:48] !== want.age) begin
          if (mismatches < 10)
            $display({"%0t: result mismatch: status %0d/%0d vx %0d/%0d vy %0d/%0d ",
                      "yaw %0d/%0d age %0d/%0d (expected/actual)"}, $realtime,
                     want.status, out_tuser, $signed(want.vx), $signed(out_tdata[15:0]),
                     $signed(want.vy), $signed(out_tdata[31:16]), $signed(want.yaw),
                     $signed(out_tdata[47:32]), want.age, out_tdata[63:48]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A velocity component, biased toward the thresholds, the limits and the
  // extremes of the 16-bit range under the present register values.
  function automatic logic [15:0] pick_velocity();
    logic [15:0] m;
    case ($urandom_range(0, 7))
      0: m = 16'($urandom_range(0, int'(lin_thresh_reg) + 2));
      1: m = 16'($urandom_range(0, int'(ang_thresh_reg) + 2));
      2: m = 16'($urandom_range(0, int'(lin_max_reg) + int'(lin_max_reg) / 4 + 2));
      3: m = 16'($urandom_range(0, int'(ang_max_reg) + int'(ang_max_reg) / 4 + 2));
      4: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      5: m = 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
    return $urandom_range(0, 1) ? 16'(-m) : m;
  endfunction

  // Register value: either anything in 16 bits (the top bit is dropped by the
  // 15-bit registers) or a moderate value.
  function automatic logic [15:0] pick_limit();
    return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4096));
  endfunction

  // Mostly well-formed sequences (command, some ticks, one or two evaluates)
  // with random content; the rest are lone transactions of any code.
  // Transactions of the unused code are not counted.
  task automatic random_traffic(int n);
    int sent;
    int seqs;
    int ticks;
    int evals;
    int r;
    logic [1:0] cmd;
    sent = 0;
    seqs = 0;
    while (sent < n) begin
      // Now and then a run of sequences goes without any idle cycles.
      if (seqs % 8 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      seqs++;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_item(CMD_VELOCITY, pick_velocity(), pick_velocity(), pick_velocity(),
                  $urandom_range(0, 6) == 0);
        // With a short timeout, some sequences tick right up to and past it.
        if (r < 20 && timeout_reg < 40)
          ticks = int'(timeout_reg) + $urandom_range(0, 2);
        else
          ticks = $urandom_range(0, 3);
        evals = $urandom_range(1, 2);
        repeat (ticks) send_random(CMD_TICK);
        repeat (evals) send_random(CMD_EVALUATE);
        sent += 1 + ticks + evals;
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send_random(cmd);
        if (cmd != CMD_UNUSED) sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values; every result kind except stale, the dead-band edges, scaling at
  // both ends of the range and the yaw clamp.
  task automatic test_directed();
    send_random(CMD_EVALUATE);                                   // wait, nothing held
    send_random(CMD_TICK);                                       // tick before any command
    send_random(CMD_EVALUATE);                                   // still wait, age field 0
    send_random(CMD_UNUSED);                                     // dropped
    send_item(CMD_VELOCITY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_random(CMD_EVALUATE);                                   // dead-band, age 0
    send_random(CMD_TICK);
    send_random(CMD_EVALUATE);                                   // dead-band, age 1
    send_item(CMD_VELOCITY, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
    send_random(CMD_EVALUATE);                                   // invalid stop
    send_item(CMD_VELOCITY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_random(CMD_EVALUATE);                                   // scaled, yaw clamped up
    send_item(CMD_VELOCITY, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_random(CMD_EVALUATE);                                   // scaled, yaw clamped down
    send_item(CMD_VELOCITY, 16'sd1000, -16'sd1000, -16'sd205, 1'b0);
    send_random(CMD_EVALUATE);                                   // move inside the limit
    send_item(CMD_VELOCITY, 16'sd204, -16'sd204, 16'sd204, 1'b0);
    send_random(CMD_EVALUATE);                                   // just inside the dead-band
    send_item(CMD_VELOCITY, 16'sd205, 16'sd0, 16'sd0, 1'b0);
    send_random(CMD_EVALUATE);                                   // on the threshold: move
    send_item(CMD_VELOCITY, 16'sd0, -16'sd3000, 16'sd0, 1'b0);
    send_random(CMD_EVALUATE);                                   // scaled onto the limit
    send_item(CMD_VELOCITY, -16'sd1, 16'sd1, -16'sd2049, 1'b0);
    send_random(CMD_EVALUATE);                                   // only yaw moves, clamped
  endtask

  // Random traffic under the register extremes, the reset values, a setting
  // where only an all-zero command falls in the dead-band, and random settings
  // with short timeouts half of the time.
  task automatic test_config_sweep();
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_traffic(ITEMS_PER_PHASE);
    configure(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    random_traffic(ITEMS_PER_PHASE);
    configure(16'd500, 16'd205, 16'd205, 16'd2048, 16'd2048);
    random_traffic(ITEMS_PER_PHASE);
    configure(16'd3, 16'd1, 16'd1, 16'd1, 16'd1);
    random_traffic(ITEMS_PER_PHASE);
    repeat (4) begin
      configure($urandom_range(0, 1) ? 16'($urandom_range(0, 30)) : 16'($urandom),
                pick_limit(), pick_limit(), pick_limit(), pick_limit());
      random_traffic(ITEMS_PER_PHASE);
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // commands, ticks and evaluates. The output register fills, a second
  // evaluate finishes and holds, and from then on the input stalls.
  task automatic test_backpressure();
    drain();
    no_gaps = 1'b1;
    @(posedge clk);
    rx_hold_req = HOLD_CYCLES;
    @(negedge clk);
    repeat (10) begin
      send_item(CMD_VELOCITY, pick_velocity(), pick_velocity(), pick_velocity(),
                $urandom_range(0, 6) == 0);
      send_random(CMD_EVALUATE);
      send_random(CMD_TICK);
      send_random(CMD_EVALUATE);
    end
    no_gaps = 1'b0;
  endtask

  // Ticks the age counter up to the timeout and one past it: an age equal to
  // the timeout is still fresh, one tick more makes the command stale.
  task automatic test_age_timeout();
    configure(16'd40, 16'd205, 16'd205, 16'd2048, 16'd2048);
    no_gaps = 1'b1;
    send_item(CMD_VELOCITY, 16'sd5000, -16'sd7000, 16'sd100, 1'b0);
    repeat (40) send_random(CMD_TICK);
    send_random(CMD_EVALUATE);
    send_random(CMD_TICK);
    send_random(CMD_EVALUATE);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_age_timeout();

    // Every prediction must have been met, and nothing may follow.
    drain();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
